// ===== src/uule_pkg.sv =====
`timescale 1ns / 1ps

package uule_pkg;

    // Line geometry
    localparam int BYTES_PER_LINE = 45;
    localparam int ADDR_W         = $clog2(BYTES_PER_LINE);
    localparam int CNT_W          = $clog2(BYTES_PER_LINE + 3);
    localparam int CHAR_W         = 7;
    localparam int STEP_W         = 3;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [STEP_W-1:0] step_t;

    localparam cnt_t  LINE_FULL    = cnt_t'(BYTES_PER_LINE);
    localparam char_t CHAR_NEWLINE = char_t'(10);
    localparam char_t CHAR_OFFSET  = char_t'(32);
    localparam char_t SUFFIX_RESET = char_t'(97);

    // Microprogram addresses
    localparam step_t STEP_IDLE = 3'd0;
    localparam step_t STEP_LEN  = 3'd1;
    localparam step_t STEP_G0   = 3'd2;
    localparam step_t STEP_G1   = 3'd3;
    localparam step_t STEP_G2   = 3'd4;
    localparam step_t STEP_G3   = 3'd5;
    localparam step_t STEP_SUF  = 3'd6;
    localparam step_t STEP_NL   = 3'd7;

    // Character source for the output register
    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_LEN,
        SRC_C0,
        SRC_C1,
        SRC_C2,
        SRC_C3,
        SRC_SUF,
        SRC_NL
    } char_src_t;

    // Byte holding register to load
    typedef enum logic [1:0] {
        LAT_NONE,
        LAT_B0,
        LAT_B1,
        LAT_B2
    } latch_sel_t;

    // Sequencing condition
    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_IF_EMPTY,
        JMP_IF_MORE,
        JMP_IF_START
    } jump_t;

    typedef struct packed {
        char_src_t  src;
        latch_sel_t lat;
        logic       inc_idx;
        logic       clr_line;
        logic       mark_end;
        logic       mark_last;
        jump_t      jmp;
        step_t      target;
    } ctrl_word_t;

    // Sequencer to datapath
    typedef struct packed {
        ctrl_word_t ctrl;
        logic       go;
        logic       in_ready;
    } seq_cmd_t;

    // Datapath to sequencer
    typedef struct packed {
        logic start;
        logic empty;
        logic more;
        logic out_free;
    } dp_status_t;

    // Map a 6-bit value onto the printable range
    function automatic char_t enc6(input logic [5:0] v);
        return {1'b0, v} + CHAR_OFFSET;
    endfunction

    // Control store
    function automatic ctrl_word_t ucode_rom(input step_t step);
        ctrl_word_t w;
        w = '0;
        case (step)
            STEP_IDLE:
            begin
                w.jmp    = JMP_IF_START;
                w.target = STEP_LEN;
            end
            STEP_LEN:
            begin
                w.src      = SRC_LEN;
                w.mark_end = 1'b1;
                w.jmp      = JMP_IF_EMPTY;
                w.target   = STEP_SUF;
            end
            STEP_G0:
            begin
                w.src     = SRC_C0;
                w.lat     = LAT_B0;
                w.inc_idx = 1'b1;
                w.jmp     = JMP_NEXT;
            end
            STEP_G1:
            begin
                w.src     = SRC_C1;
                w.lat     = LAT_B1;
                w.inc_idx = 1'b1;
                w.jmp     = JMP_NEXT;
            end
            STEP_G2:
            begin
                w.src     = SRC_C2;
                w.lat     = LAT_B2;
                w.inc_idx = 1'b1;
                w.jmp     = JMP_NEXT;
            end
            STEP_G3:
            begin
                w.src    = SRC_C3;
                w.jmp    = JMP_IF_MORE;
                w.target = STEP_G0;
            end
            STEP_SUF:
            begin
                w.src      = SRC_SUF;
                w.mark_end = 1'b1;
                w.jmp      = JMP_NEXT;
            end
            STEP_NL:
            begin
                w.src       = SRC_NL;
                w.mark_end  = 1'b1;
                w.mark_last = 1'b1;
                w.clr_line  = 1'b1;
                w.jmp       = JMP_ALWAYS;
                w.target    = STEP_IDLE;
            end
            default:
            begin
                w.jmp    = JMP_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== src/uuencode_line_encoder_top.sv =====
`timescale 1ns / 1ps
// A run's word takes the step counter out of idle; the length step loads the first character
// once the output register is free. A data word that does not fill the line is taken in
// idle. n bytes send 4*ceil(n/3)+3 characters, 63 for a full line, from the microcode step
// counter, one per cycle unless stalled; no input word is taken until its newline is loaded.
// Reset: step counter, fill count and output valid clear, suffix returns to 'a' (97);
// line store contents are left as they are and need no clearing pass.

module uuencode_line_encoder_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       command,
    input  logic [7:0] data_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [6:0] line_suffix,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] out_char,
    output logic       last_of_run,
    output logic       end_marker
);

    uule_pkg::seq_cmd_t   cmd;
    uule_pkg::dp_status_t status;

    assign in_ready  = cmd.in_ready;
    assign cfg_ready = 1'b1;

    uule_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    uule_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .command     (command),
        .data_byte   (data_byte),
        .cfg_valid   (cfg_valid),
        .line_suffix (line_suffix),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .out_char    (out_char),
        .last_of_run (last_of_run),
        .end_marker  (end_marker),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ===== src/uule_sequencer.sv =====
`timescale 1ns / 1ps

module uule_sequencer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  uule_pkg::dp_status_t  status,
    output uule_pkg::seq_cmd_t    cmd
);

    uule_pkg::step_t      step_reg;
    uule_pkg::step_t      step_next;
    uule_pkg::step_t      step_seq;
    uule_pkg::ctrl_word_t ctrl;
    logic                 go;

    // Fetch the control word for the current step
    assign ctrl     = uule_pkg::ucode_rom(step_reg);
    assign step_seq = step_reg + 1'b1;

    // Hold a character step until the output register is free
    assign go = (ctrl.src == uule_pkg::SRC_NONE) || status.out_free;

    assign cmd.ctrl     = ctrl;
    assign cmd.go       = go;
    assign cmd.in_ready = (step_reg == uule_pkg::STEP_IDLE);

    // Resolve the next step
    always_comb
    begin
        case (ctrl.jmp)
            uule_pkg::JMP_NEXT:     step_next = step_seq;
            uule_pkg::JMP_ALWAYS:   step_next = ctrl.target;
            uule_pkg::JMP_IF_EMPTY: step_next = status.empty ? ctrl.target : step_seq;
            uule_pkg::JMP_IF_MORE:  step_next = status.more ? ctrl.target : step_seq;
            uule_pkg::JMP_IF_START: step_next = status.start ? ctrl.target : step_reg;
            default:                step_next = uule_pkg::STEP_IDLE;
        endcase
        if (!go)
        begin
            step_next = step_reg;
        end
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= uule_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== src/uule_datapath.sv =====
`timescale 1ns / 1ps

module uule_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  command,
    input  logic [7:0]            data_byte,
    input  logic                  cfg_valid,
    input  logic [6:0]            line_suffix,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [6:0]            out_char,
    output logic                  last_of_run,
    output logic                  end_marker,
    input  uule_pkg::seq_cmd_t    cmd,
    output uule_pkg::dp_status_t  status
);

    logic [7:0]       mem [0:uule_pkg::BYTES_PER_LINE-1];

    uule_pkg::cnt_t   count_reg;
    uule_pkg::cnt_t   count_next;
    uule_pkg::cnt_t   count_inc;
    uule_pkg::cnt_t   idx_reg;
    uule_pkg::cnt_t   idx_next;
    logic [7:0]       rdata_reg;
    logic [7:0]       b0_reg;
    logic [7:0]       b1_reg;
    logic [7:0]       b2_reg;
    logic [7:0]       cur_byte;
    uule_pkg::char_t  suffix_reg;
    logic             out_valid_reg;
    uule_pkg::char_t  out_char_reg;
    logic             out_last_reg;
    logic             out_end_reg;
    uule_pkg::char_t  char_sel;
    logic             accept;
    logic             wr_data;
    logic             load;

    // Input side
    assign accept    = in_valid && cmd.in_ready;
    assign wr_data   = accept && !command;
    assign count_inc = count_reg + 1'b1;

    assign status.start    = accept && (command || (count_inc == uule_pkg::LINE_FULL));
    assign status.empty    = (count_reg == '0);
    assign status.more     = (idx_reg < count_reg);
    assign status.out_free = !out_valid_reg || out_ready;

    assign load = cmd.go && (cmd.ctrl.src != uule_pkg::SRC_NONE);

    // Bytes past the line length read as zero padding
    assign cur_byte = status.more ? rdata_reg : 8'h00;

    // Next fill count and read pointer
    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        if (wr_data)
        begin
            count_next = count_inc;
        end
        else if (cmd.go && cmd.ctrl.clr_line)
        begin
            count_next = '0;
        end
        if (cmd.go && cmd.ctrl.clr_line)
        begin
            idx_next = '0;
        end
        else if (cmd.go && cmd.ctrl.inc_idx)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    // Line store: write on a data word, read ahead at the next pointer
    always_ff @(posedge clk)
    begin
        if (wr_data)
        begin
            mem[count_reg[uule_pkg::ADDR_W-1:0]] <= data_byte;
        end
        if (idx_next < uule_pkg::LINE_FULL)
        begin
            rdata_reg <= mem[idx_next[uule_pkg::ADDR_W-1:0]];
        end
    end

    // Group byte holding registers
    always_ff @(posedge clk)
    begin
        if (cmd.go)
        begin
            case (cmd.ctrl.lat)
                uule_pkg::LAT_B0: b0_reg <= cur_byte;
                uule_pkg::LAT_B1: b1_reg <= cur_byte;
                uule_pkg::LAT_B2: b2_reg <= cur_byte;
                default:          ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            suffix_reg    <= uule_pkg::SUFFIX_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (cfg_valid)
            begin
                suffix_reg <= line_suffix;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Select the character for this step
    always_comb
    begin
        case (cmd.ctrl.src)
            uule_pkg::SRC_LEN: char_sel = uule_pkg::enc6(6'(count_reg));
            uule_pkg::SRC_C0:  char_sel = uule_pkg::enc6(cur_byte[7:2]);
            uule_pkg::SRC_C1:  char_sel = uule_pkg::enc6({b0_reg[1:0], cur_byte[7:4]});
            uule_pkg::SRC_C2:  char_sel = uule_pkg::enc6({b1_reg[3:0], cur_byte[7:6]});
            uule_pkg::SRC_C3:  char_sel = uule_pkg::enc6(b2_reg[5:0]);
            uule_pkg::SRC_SUF: char_sel = suffix_reg;
            uule_pkg::SRC_NL:  char_sel = uule_pkg::CHAR_NEWLINE;
            default:           char_sel = '0;
        endcase
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg <= char_sel;
            out_last_reg <= cmd.ctrl.mark_last;
            out_end_reg  <= cmd.ctrl.mark_end && status.empty;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign last_of_run = out_last_reg;
    assign end_marker  = out_end_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= uule_pkg::LINE_FULL)
        else $error("fill count beyond line length");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, idx_reg} <= ({1'b0, count_reg} + (uule_pkg::CNT_W+1)'(2)))
        else $error("read pointer past last group");

    a_no_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !load)
        else $error("input word taken during a run");

    a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (load && cmd.ctrl.mark_last) |=> (count_reg == '0) && (idx_reg == '0))
        else $error("line state not cleared after newline");
`endif

endmodule

// ===== tb/sv/uuencode_line_encoder_top_tb.sv =====
`timescale 1ns / 1ps

module uuencode_line_encoder_top_tb;

    localparam int   LINE_BYTES  = uule_pkg::BYTES_PER_LINE;
    localparam int   CYCLE_LIMIT = 1_000_000;
    localparam logic CMD_DATA    = 1'b0;
    localparam logic CMD_FINISH  = 1'b1;

    typedef struct {
        logic       op;
        logic [7:0] value;
    } in_word_t;

    typedef struct {
        logic [6:0] ch;
        logic       last;
        logic       endm;
    } char_word_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic       command     = CMD_DATA;
    logic [7:0] data_byte   = 8'h00;
    logic       cfg_valid   = 1'b0;
    logic       cfg_ready;
    logic [6:0] line_suffix = uule_pkg::SUFFIX_RESET;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [6:0] out_char;
    logic       last_of_run;
    logic       end_marker;

    in_word_t   pending_words[$];
    char_word_t expected_chars[$];
    char_word_t want_char;
    in_word_t   next_word;

    // Line buffer mirror and current suffix
    logic [7:0] line_bytes[LINE_BYTES];
    int         fill_count = 0;
    logic [6:0] suffix_now = uule_pkg::SUFFIX_RESET;

    int gap_left   = 0;
    int stall_left = 0;
    int calm_left  = 0;
    int errors     = 0;
    int cycles     = 0;

    uuencode_line_encoder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .data_byte   (data_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .line_suffix (line_suffix),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .last_of_run (last_of_run),
        .end_marker  (end_marker)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Mostly short gaps, a few long ones, and now and then a quiet stretch
    function automatic int pick_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [6:0] printable(input logic [5:0] v);
        return {1'b0, v} + 7'd32;
    endfunction

    task automatic push_char(input logic [6:0] c, input logic last, input logic endm);
        char_word_t w;
        w.ch   = c;
        w.last = last;
        w.endm = endm;
        expected_chars.push_back(w);
    endtask

    // Expand n buffered bytes into the character run of one line
    task automatic emit_line_chars(input int n);
        logic       endm;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        int         i;
        endm = (n == 0);
        push_char(printable(6'(n)), 1'b0, endm);
        for (i = 0; i < n; i += 3)
        begin
            b0 = line_bytes[i];
            b1 = (i + 1 < n) ? line_bytes[i + 1] : 8'h00;
            b2 = (i + 2 < n) ? line_bytes[i + 2] : 8'h00;
            push_char(printable(b0[7:2]), 1'b0, 1'b0);
            push_char(printable({b0[1:0], b1[7:4]}), 1'b0, 1'b0);
            push_char(printable({b1[3:0], b2[7:6]}), 1'b0, 1'b0);
            push_char(printable(b2[5:0]), 1'b0, 1'b0);
        end
        push_char(suffix_now, 1'b0, endm);
        push_char(uule_pkg::CHAR_NEWLINE, 1'b1, endm);
    endtask

    // Update the line mirror for one accepted word
    task automatic encode_word(input logic op, input logic [7:0] value);
        if (op == CMD_DATA)
        begin
            line_bytes[fill_count] = value;
            fill_count++;
            if (fill_count == LINE_BYTES)
            begin
                emit_line_chars(fill_count);
                fill_count = 0;
            end
        end
        else
        begin
            emit_line_chars(fill_count);
            fill_count = 0;
        end
    endtask

    task automatic queue_word(input logic op, input logic [7:0] value);
        in_word_t w;
        w.op    = op;
        w.value = value;
        pending_words.push_back(w);
    endtask

    // Lines of random content, ended by finish where short; a full line opens a long phase
    task automatic queue_random_phase(input int target);
        int count;
        int len;
        int r;
        int k;
        count = 0;
        while (count < target)
        begin
            r = $urandom_range(0, 99);
            if ((count == 0 && target >= LINE_BYTES) || r < 15)
                len = LINE_BYTES;
            else if (r < 45)
                len = $urandom_range(0, 3);
            else
                len = $urandom_range(4, 20);
            for (k = 0; k < len; k++)
                queue_word(CMD_DATA, 8'($urandom_range(0, 255)));
            if (len < LINE_BYTES || $urandom_range(0, 3) == 0)
                queue_word(CMD_FINISH, 8'($urandom_range(0, 255)));
            count += len + 1;
        end
    endtask

    // Hold until every word is taken and every character is back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_chars.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_suffix(input logic [6:0] v);
        cfg_valid   <= 1'b1;
        line_suffix <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        suffix_now = v;
    endtask

    // Input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            gap_left   = 0;
            fill_count = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                encode_word(command, data_byte);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    next_word = pending_words.pop_front();
                    in_valid  <= 1'b1;
                    command   <= next_word.op;
                    data_byte <= next_word.value;
                    gap_left  = pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: unexpected word expected none actual char=%h last=%b end=%b",
                             $time, out_char, last_of_run, end_marker);
                    errors++;
                end
                else
                begin
                    want_char = expected_chars.pop_front();
                    if (out_char !== want_char.ch)
                    begin
                        $display("%0t: out_char expected %h actual %h",
                                 $time, want_char.ch, out_char);
                        errors++;
                    end
                    if (last_of_run !== want_char.last)
                    begin
                        $display("%0t: last_of_run expected %b actual %b",
                                 $time, want_char.last, last_of_run);
                        errors++;
                    end
                    if (end_marker !== want_char.endm)
                    begin
                        $display("%0t: end_marker expected %b actual %b",
                                 $time, want_char.endm, end_marker);
                        errors++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready  <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Drop the run if it hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Terminator straight out of reset
        queue_word(CMD_FINISH, 8'hFF);
        // Short final groups padded with zero bytes
        queue_word(CMD_DATA, 8'h00);
        queue_word(CMD_FINISH, 8'h00);
        queue_word(CMD_DATA, 8'hFF);
        queue_word(CMD_FINISH, 8'h5A);
        queue_word(CMD_DATA, 8'hFF);
        queue_word(CMD_DATA, 8'h00);
        queue_word(CMD_FINISH, 8'h00);
        // Exact group, then one full group plus a single byte
        queue_word(CMD_DATA, 8'h80);
        queue_word(CMD_DATA, 8'h01);
        queue_word(CMD_DATA, 8'h7F);
        queue_word(CMD_FINISH, 8'h00);
        queue_word(CMD_DATA, 8'hA5);
        queue_word(CMD_DATA, 8'h5A);
        queue_word(CMD_DATA, 8'hC3);
        queue_word(CMD_DATA, 8'h3C);
        queue_word(CMD_FINISH, 8'hFF);
        // Finish after a flushed line gives the terminator, twice over
        queue_word(CMD_FINISH, 8'h00);
        queue_word(CMD_FINISH, 8'hFF);
        wait_idle();

        write_suffix(7'd126);
        queue_random_phase(LINE_BYTES);
        wait_idle();

        write_suffix(7'd32);
        queue_random_phase(12);
        wait_idle();

        write_suffix(7'($urandom_range(33, 125)));
        queue_random_phase(12);
        wait_idle();

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
